// ===== sv/sorted_key_value_table_unit_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the sorted key/value table
// Concurrent checks clocked on i_clk, held off while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef SORTED_KEY_VALUE_TABLE_UNIT_ASSERT_SVH
`define SORTED_KEY_VALUE_TABLE_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

// cond must never hold
`define SKVT_ASSERT_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) \
        else $error(msg);

// ante implies cons in the same cycle
`define SKVT_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// ante implies cons in the next cycle
`define SKVT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define SKVT_ASSERT_NEVER(lbl, cond, msg)
`define SKVT_ASSERT_IMPL(lbl, ante, cons, msg)
`define SKVT_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

// ===== sv/skvt_pkg.sv =====
// ----------------------------------------------------------------------------
// skvt_pkg
// Shared types and constants of the sorted key/value table.
// ----------------------------------------------------------------------------
package skvt_pkg;

    localparam int KEY_BITS       = 32;
    localparam int VALUE_BITS     = 32;
    localparam int COUNT_OUT_BITS = 7;

    // operation codes
    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_FIND   = 2'd1;
    localparam logic [1:0] OP_REMOVE = 2'd2;
    localparam logic [1:0] OP_CLEAR  = 2'd3;

    typedef struct packed {
        logic [1:0]            operation;
        logic [KEY_BITS-1:0]   key;
        logic [VALUE_BITS-1:0] value;
    } t_in_word;

    typedef struct packed {
        logic                      hit;
        logic [VALUE_BITS-1:0]     value_out;
        logic                      status;
        logic [COUNT_OUT_BITS-1:0] entry_count;
    } t_out_word;

    // per-cell strobes, broadcast down the row
    typedef struct packed {
        logic cmp;  // latch compare flags
        logic ins;  // open a slot and insert
        logic rem;  // close the slot of the match
        logic rep;  // overwrite the value of the match
    } t_cell_ctl;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CMP,
        ST_UPD
    } t_state;

endpackage

// ===== sv/skvt_cell.sv =====
// ----------------------------------------------------------------------------
// skvt_cell
// One slot of the sorted row: compares against the probe key and shifts
// its pair to or from a neighbor on insert and remove.
// ----------------------------------------------------------------------------
module skvt_cell (
    input  logic                            i_clk,
    input  skvt_pkg::t_cell_ctl             i_ctl,
    input  logic                            i_signed,
    input  logic                            i_occ,
    input  logic [skvt_pkg::KEY_BITS-1:0]   i_probe_key,
    input  logic [skvt_pkg::VALUE_BITS-1:0] i_new_value,
    input  logic                            i_pos,
    input  logic [skvt_pkg::KEY_BITS-1:0]   i_left_key,
    input  logic [skvt_pkg::VALUE_BITS-1:0] i_left_value,
    input  logic                            i_left_pos,
    input  logic [skvt_pkg::KEY_BITS-1:0]   i_right_key,
    input  logic [skvt_pkg::VALUE_BITS-1:0] i_right_value,
    output logic [skvt_pkg::KEY_BITS-1:0]   o_key,
    output logic [skvt_pkg::VALUE_BITS-1:0] o_value,
    output logic                            o_pos,
    output logic                            o_eq,
    output logic [skvt_pkg::VALUE_BITS-1:0] o_hit_value
);
    import skvt_pkg::*;

    logic [KEY_BITS-1:0]   r_key, n_key;
    logic [VALUE_BITS-1:0] r_value, n_value;
    logic                  r_ge, n_ge;
    logic                  r_eq, n_eq;
    logic [KEY_BITS-1:0]   flip;
    logic                  hit_here;

    // signed order: flipping the sign bit maps it onto unsigned order
    assign flip = {i_signed, {(KEY_BITS-1){1'b0}}};

    always_comb begin
        n_ge = r_ge;
        n_eq = r_eq;
        if (i_ctl.cmp) begin
            n_ge = i_occ && ((r_key ^ flip) >= (i_probe_key ^ flip));
            n_eq = i_occ && (r_key == i_probe_key);
        end
    end

    // own key not below the probe, or slot free
    assign o_pos = r_ge || !i_occ;

    // only the first slot at the insert/remove point can match
    assign hit_here = r_eq && i_pos && !i_left_pos;

    always_comb begin
        n_key   = r_key;
        n_value = r_value;
        if (i_ctl.ins && i_pos) begin
            if (i_left_pos) begin
                n_key   = i_left_key;
                n_value = i_left_value;
            end else begin
                n_key   = i_probe_key;
                n_value = i_new_value;
            end
        end else if (i_ctl.rem && i_pos) begin
            n_key   = i_right_key;
            n_value = i_right_value;
        end else if (i_ctl.rep && hit_here) begin
            n_value = i_new_value;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key   <= n_key;
        r_value <= n_value;
        r_ge    <= n_ge;
        r_eq    <= n_eq;
    end

    assign o_key       = r_key;
    assign o_value     = r_value;
    assign o_eq        = hit_here;
    assign o_hit_value = hit_here ? r_value : '0;

endmodule

// ===== sv/sorted_key_value_table_unit.sv =====
// ----------------------------------------------------------------------------
// sorted_key_value_table_unit
// Sorted key/value table built as a row of MAP_DEPTH cells. Every cell
// compares its key with the probe at once; insert and remove move pairs one
// cell up or down the row, all cells at once.
// ----------------------------------------------------------------------------
//
//  channel   | direction | handshake                 | word
//  ----------+-----------+---------------------------+-------------------------
//  request   | in        | i_in_valid / o_in_stall   | i_in_word  (t_in_word)
//  result    | out       | o_out_valid / i_out_stall | o_out_word (t_out_word)
//  config    | in        | i_cfg_wr_en               | i_cfg_wr_data (signed_keys)
//
//  Requests are handled one at a time: accept, compare in all cells, update the row.
//  A new request is taken only after the row update of the last one is done.
//  A finished word sits in the output register; the next request is taken
//  while it waits, and the row update holds only if that register is full
//  and stalled.
//  Synchronous active-low reset empties the table and clears signed_keys.
//  Slot contents are not cleared; slots at or above the count are ignored.
// ----------------------------------------------------------------------------
`include "sorted_key_value_table_unit_assert.svh"

module sorted_key_value_table_unit #(
    parameter int MAP_DEPTH = 64
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  skvt_pkg::t_in_word  i_in_word,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output skvt_pkg::t_out_word o_out_word,
    input  logic                i_cfg_wr_en,
    input  logic                i_cfg_wr_data
);
    import skvt_pkg::*;

    localparam int CNT_W = $clog2(MAP_DEPTH + 1);

    // FSM and control
    t_state    r_state, n_state;
    t_cell_ctl ctl;
    logic      fire;        // row update and result load happen this cycle

    // held request
    logic [1:0]            r_op;
    logic [KEY_BITS-1:0]   r_key;
    logic [VALUE_BITS-1:0] r_value;

    logic             r_signed;
    logic [CNT_W-1:0] r_count, n_count;

    // output register
    logic      r_out_valid, n_out_valid;
    t_out_word r_out_word, n_out_word;

    // cell row taps
    logic [KEY_BITS-1:0]   cell_key   [MAP_DEPTH];
    logic [VALUE_BITS-1:0] cell_value [MAP_DEPTH];
    logic [VALUE_BITS-1:0] cell_hitv  [MAP_DEPTH];
    logic [MAP_DEPTH-1:0]  cell_pos;
    logic [MAP_DEPTH-1:0]  cell_eq;
    logic [MAP_DEPTH-1:0]  occ;
    logic [MAP_DEPTH-1:0]  at_pos;  // at or past the first slot not below the probe

    logic                  present;
    logic                  full;
    logic [VALUE_BITS-1:0] hit_value;

    // ------------------------------------------------------------------
    // Insert/remove point: prefix OR of the per-cell flags, so that a row
    // left out of order by a key order switch still splits at the first
    // flagged slot. Log-depth doubling, no ripple.
    // ------------------------------------------------------------------
    always_comb begin
        at_pos = cell_pos;
        for (int s = 1; s < MAP_DEPTH; s = s * 2) begin
            at_pos = at_pos | (at_pos << s);
        end
    end

    // ------------------------------------------------------------------
    // Cell row. Cell 0 has no left neighbor (never shifted into from the
    // left); the last cell's right neighbor is itself.
    // ------------------------------------------------------------------
    for (genvar g = 0; g < MAP_DEPTH; g++) begin : g_cell
        logic [KEY_BITS-1:0]   left_key;
        logic [VALUE_BITS-1:0] left_value;
        logic                  left_pos;
        logic [KEY_BITS-1:0]   right_key;
        logic [VALUE_BITS-1:0] right_value;

        assign occ[g] = r_count > CNT_W'(g);

        if (g == 0) begin : g_first
            assign left_key   = cell_key[g];
            assign left_value = cell_value[g];
            assign left_pos   = 1'b0;
        end else begin : g_mid
            assign left_key   = cell_key[g-1];
            assign left_value = cell_value[g-1];
            assign left_pos   = at_pos[g-1];
        end

        if (g == MAP_DEPTH - 1) begin : g_last
            assign right_key   = cell_key[g];
            assign right_value = cell_value[g];
        end else begin : g_inner
            assign right_key   = cell_key[g+1];
            assign right_value = cell_value[g+1];
        end

        skvt_cell u_cell (
            .i_clk         (i_clk),
            .i_ctl         (ctl),
            .i_signed      (r_signed),
            .i_occ         (occ[g]),
            .i_probe_key   (r_key),
            .i_new_value   (r_value),
            .i_pos         (at_pos[g]),
            .i_left_key    (left_key),
            .i_left_value  (left_value),
            .i_left_pos    (left_pos),
            .i_right_key   (right_key),
            .i_right_value (right_value),
            .o_key         (cell_key[g]),
            .o_value       (cell_value[g]),
            .o_pos         (cell_pos[g]),
            .o_eq          (cell_eq[g]),
            .o_hit_value   (cell_hitv[g])
        );
    end

    // only the first slot at the insert point can match: OR picks its value
    always_comb begin
        hit_value = '0;
        for (int i = 0; i < MAP_DEPTH; i++) begin
            hit_value = hit_value | cell_hitv[i];
        end
    end

    assign present = |cell_eq;
    assign full    = r_count == CNT_W'(MAP_DEPTH);

    // ------------------------------------------------------------------
    // FSM: next state
    // ------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) n_state = ST_CMP;
            end
            ST_CMP: begin
                n_state = ST_UPD;
            end
            ST_UPD: begin
                if (!r_out_valid || !i_out_stall) n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // FSM: outputs
    // ------------------------------------------------------------------
    always_comb begin
        o_in_stall = 1'b1;
        fire       = 1'b0;
        ctl        = '0;
        case (r_state)
            ST_IDLE: begin
                o_in_stall = 1'b0;
            end
            ST_CMP: begin
                ctl.cmp = 1'b1;
            end
            ST_UPD: begin
                fire    = !r_out_valid || !i_out_stall;
                ctl.ins = fire && (r_op == OP_INSERT) && !present && !full;
                ctl.rep = fire && (r_op == OP_INSERT) && present;
                ctl.rem = fire && (r_op == OP_REMOVE) && present;
            end
            default: begin
                o_in_stall = 1'b1;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // count and result word
    // ------------------------------------------------------------------
    always_comb begin
        n_count = r_count;
        if (fire) begin
            if (r_op == OP_CLEAR) begin
                n_count = '0;
            end else if (ctl.ins) begin
                n_count = r_count + CNT_W'(1);
            end else if (ctl.rem) begin
                n_count = r_count - CNT_W'(1);
            end
        end
    end

    always_comb begin
        n_out_word = r_out_word;
        if (fire) begin
            n_out_word.hit         = present && (r_op != OP_CLEAR);
            n_out_word.value_out   = (r_op != OP_CLEAR) ? hit_value : '0;
            n_out_word.status      = (r_op == OP_INSERT) && !present && full;
            n_out_word.entry_count = COUNT_OUT_BITS'(n_count);
        end
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (fire) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
            r_signed    <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
            if (i_cfg_wr_en) r_signed <= i_cfg_wr_data;
        end
    end

    // request and result payload, no reset
    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_op    <= i_in_word.operation;
            r_key   <= i_in_word.key;
            r_value <= i_in_word.value;
        end
        r_out_word <= n_out_word;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    `SKVT_ASSERT_NEVER(a_count_bound, r_count > CNT_W'(MAP_DEPTH), "count past table depth")
    `SKVT_ASSERT_IMPL(a_single_match, r_state == ST_UPD, $onehot0(cell_eq), "two cells match")
    `SKVT_ASSERT_NEXT(a_fire_result, fire, r_out_valid && r_state == ST_IDLE, "result not loaded")
    `SKVT_ASSERT_IMPL(a_full_status, r_out_valid && r_out_word.status, full, "refused but not full")

endmodule
